// File: hw/rtl/rdd_pkg.sv
// Shared types and constants of the resend duplicate detector.
// Used by the front end, the request queue, the back end and the top level.
`default_nettype none

package rdd_pkg;

  // Default packet store depth in bytes.
  localparam int unsigned MaxBytes = 256;

  // Number of entries in the queue between the front and back ends.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // One classified byte request, handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] data;       // received byte
    logic [7:0] rdata;      // stored byte at the same position
    logic       cmp_en;     // byte of a resend that lies inside the store
    logic       resend;     // packet carries the resend mark
    logic       last;       // final byte of the packet
    logic       len_match;  // on the final byte: length equals stored length
  } rdd_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/rdd_front.sv
// Front end: accepts bytes, tracks the position and packet kind, owns the
// packet store and stored length, and issues classified requests. Uses rdd_pkg.
`default_nettype none

module rdd_front
  import rdd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MaxBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       resend_mark_i,
  input  wire logic       last_byte_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output rdd_req_t        req_o,
  output logic            req_valid_o,
  input  wire logic       req_ready_i
);

  localparam int unsigned PosW  = $clog2(MAX_BYTES + 1);
  localparam int unsigned AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic            accept;
  logic            stg_move;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] len_q, len_d;
  logic [PosW-1:0] length;
  logic            resend_latched_q, resend_latched_d;
  logic            resend;
  logic            in_range;
  logic [AddrW-1:0] addr;
  logic            stg_valid_q;
  rdd_req_t        stg_q;
  logic [7:0]      rd_q;
  logic [7:0]      mem [MAX_BYTES];

  // The stage takes a new byte whenever it is empty or hands its request on.
  assign stg_move   = stg_valid_q && req_ready_i;
  assign in_ready_o = !stg_valid_q || req_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classification of the current byte.
  assign resend   = (pos_q == '0) ? resend_mark_i : resend_latched_q;
  assign in_range = pos_q < PosW'(MAX_BYTES);
  assign addr     = pos_q[AddrW-1:0];
  assign length   = in_range ? pos_q + PosW'(1) : pos_q;

  // Next position, packet kind and stored length.
  always_comb begin
    pos_d            = pos_q;
    resend_latched_d = resend_latched_q;
    len_d            = len_q;
    if (accept) begin
      resend_latched_d = resend;
      if (last_byte_i) begin
        pos_d = '0;
        if (!resend) begin
          len_d = length;
        end
      end else begin
        pos_d = length;
      end
    end
  end

  // Control registers and the request stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q            <= '0;
      len_q            <= '0;
      resend_latched_q <= 1'b0;
      stg_valid_q      <= 1'b0;
    end else begin
      pos_q            <= pos_d;
      len_q            <= len_d;
      resend_latched_q <= resend_latched_d;
      if (accept) begin
        stg_valid_q <= 1'b1;
      end else if (stg_move) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  // Stage payload; the stored byte arrives through the memory read register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.data      <= data_byte_i;
      stg_q.rdata     <= '0;
      stg_q.cmp_en    <= resend && in_range;
      stg_q.resend    <= resend;
      stg_q.last      <= last_byte_i;
      stg_q.len_match <= length == len_q;
    end
  end

  // Packet store: originals write, resends read, at most one access per byte.
  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      if (resend) begin
        rd_q <= mem[addr];
      end else begin
        mem[addr] <= data_byte_i;
      end
    end
  end

  // Request towards the queue.
  always_comb begin
    req_o       = stg_q;
    req_o.rdata = rd_q;
  end
  assign req_valid_o = stg_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/rdd_fifo.sv
// Short request queue between the front and back ends.
// Uses rdd_pkg for the request type and depth.
`default_nettype none

module rdd_fifo
  import rdd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire rdd_req_t push_req_i,
  input  wire logic     push_valid_i,
  output logic          push_ready_o,
  output rdd_req_t      pop_req_o,
  output logic          pop_valid_o,
  input  wire logic     pop_ready_i
);

  rdd_req_t              entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  cnt_q;
  logic                  push, pop;

  assign push_ready_o = cnt_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rdd_back.sv
// Back end: compares resend bytes, keeps the resend memory and delivers the
// verdict of each packet through an output register. Uses rdd_pkg.
`default_nettype none

module rdd_back
  import rdd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire rdd_req_t req_i,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  output logic          is_duplicate_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i
);

  logic mismatch_q, prev_resend_q;
  logic out_valid_q, dup_q;
  logic pop;
  logic mismatch;
  logic dup;

  // A final byte waits until the output register is free or being emptied.
  assign req_ready_o = !req_i.last || !out_valid_q || out_ready_i;
  assign pop         = req_valid_i && req_ready_o;

  assign mismatch = mismatch_q || (req_i.cmp_en && (req_i.rdata != req_i.data));
  assign dup      = req_i.resend && !prev_resend_q && req_i.len_match && !mismatch;

  // Comparison state, resend memory and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_q    <= 1'b0;
      prev_resend_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        if (req_i.last) begin
          mismatch_q    <= 1'b0;
          prev_resend_q <= req_i.resend && !dup;
          out_valid_q   <= 1'b1;
        end else begin
          mismatch_q <= mismatch;
        end
      end
    end
  end

  // Verdict payload.
  always_ff @(posedge clk_i) begin
    if (pop && req_i.last) begin
      dup_q <= dup;
    end
  end

  assign is_duplicate_o = dup_q;
  assign out_valid_o    = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/resend_duplicate_detector_unit.sv
// Top level of the resend duplicate detector: front end, request queue and
// back end. Uses rdd_pkg, rdd_front, rdd_fifo and rdd_back.
//
//   Channel  Handshake                    Payload
//   in       in_valid_i / in_ready_o      data_byte_i, resend_mark_i, last_byte_i
//   out      out_valid_o / out_ready_i    is_duplicate_o
//
// One byte is accepted per cycle unless stalled; the packet store does at most one
// read or write per byte. A verdict passes the stage, queue and output register.
// Reset clears position, lengths and resend memory; the store needs no clearing.
// A stalled output fills the two-entry queue, after which the input stalls too.
`default_nettype none

module resend_duplicate_detector_unit
  import rdd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MaxBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       resend_mark_i,
  input  wire logic       last_byte_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            is_duplicate_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);

  rdd_req_t front_req, back_req;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  // Byte intake and classification.
  rdd_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .resend_mark_i(resend_mark_i),
    .last_byte_i  (last_byte_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_o        (front_req),
    .req_valid_o  (front_valid),
    .req_ready_i  (front_ready)
  );

  // Decoupling queue.
  rdd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_req_i  (front_req),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .pop_req_o   (back_req),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready)
  );

  // Comparison and verdict.
  rdd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (back_req),
    .req_valid_i   (back_valid),
    .req_ready_o   (back_ready),
    .is_duplicate_o(is_duplicate_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  // A final byte never overwrites a verdict that is still waiting.
  a_no_verdict_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_valid && back_ready && back_req.last) |-> (!out_valid_o || out_ready_i))
    else $error("final byte consumed while a verdict was still pending");

  // An original packet is never reported as a duplicate.
  a_original_not_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_valid && back_ready && back_req.last && !back_req.resend) |=> !is_duplicate_o)
    else $error("original packet flagged as duplicate");

  // Each final byte handed to the back end yields a verdict in the next cycle.
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_valid && back_ready && back_req.last) |=> out_valid_o)
    else $error("verdict missing after final byte");

endmodule

`default_nettype wire

// File: tb/resend_duplicate_detector_unit_tb.sv
// Self-checking testbench for the resend duplicate detector top level.
// Drives packets byte by byte with random idling and stalls, predicts each verdict in a
// tracker class and compares it with the block's output. Depends on rdd_pkg and the RTL.
`timescale 1ns / 1ps

module resend_duplicate_detector_unit_tb;
  import rdd_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned PhaseBytes = 180;

  // Predicts the verdict of each finished packet and checks the block against it.
  class verdict_tracker;
    logic [7:0]  stored_bytes [0:MaxBytes-1];
    logic [8:0]  stored_len;
    logic        resend_flagged;
    logic [8:0]  byte_pos;
    logic        byte_differs;
    logic        packet_resend;
    bit          expected_verdicts [$];
    int unsigned failures;

    function new();
      stored_len     = '0;
      resend_flagged = 1'b0;
      byte_pos       = '0;
      byte_differs   = 1'b0;
      packet_resend  = 1'b0;
      failures       = 0;
    endfunction

    // Notes one accepted byte request; a final byte yields one expected verdict.
    function void take_byte(logic [7:0] b, logic mark, logic last);
      logic [8:0] len;
      if (byte_pos == 0) begin
        packet_resend = mark;
        byte_differs  = 1'b0;
      end
      // Bytes past the store depth are neither stored nor compared.
      if (byte_pos < MaxBytes) begin
        if (packet_resend) begin
          if (stored_bytes[byte_pos[7:0]] !== b) byte_differs = 1'b1;
        end else begin
          stored_bytes[byte_pos[7:0]] = b;
        end
        byte_pos = byte_pos + 9'd1;
      end
      if (last) begin
        len      = byte_pos;
        byte_pos = '0;
        if (!packet_resend) begin
          stored_len     = len;
          resend_flagged = 1'b0;
          expected_verdicts.push_back(1'b0);
        end else if (!resend_flagged && len == stored_len && !byte_differs) begin
          resend_flagged = 1'b0;
          expected_verdicts.push_back(1'b1);
        end else begin
          resend_flagged = 1'b1;
          expected_verdicts.push_back(1'b0);
        end
        byte_differs = 1'b0;
      end
    endfunction

    // Compares one accepted verdict with the oldest prediction.
    function void check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected verdict %b with none outstanding", got);
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10) $display("verdict mismatch: expected %b, got %b", want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic       resend_mark_i = 1'b0;
  logic       last_byte_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       is_duplicate_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  verdict_tracker tracker;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned bytes_sent = 0;

  // Stimulus-side copy of what the originals have left in the store, used to build resends.
  logic [7:0]  sent_store [0:MaxBytes-1];
  int unsigned sent_len = 0;
  int unsigned written_span = 0;
  logic [7:0]  pkt [$];

  resend_duplicate_detector_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .resend_mark_i  (resend_mark_i),
    .last_byte_i    (last_byte_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .is_duplicate_o (is_duplicate_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  always #5 clk_i = ~clk_i;

  // Offers one byte request, with random idle cycles ahead of it, and waits for acceptance.
  task automatic push_byte(input logic [7:0] b, input logic mark, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    resend_mark_i <= mark;
    last_byte_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(b, mark, last);
    bytes_sent++;
  endtask

  // Sends the bytes in pkt as one packet. The mark only matters on the first byte,
  // so the later ones carry random marks.
  task automatic send_packet(input logic mark);
    for (int i = 0; i < pkt.size(); i++) begin
      push_byte(pkt[i], (i == 0) ? mark : 1'($urandom_range(1)), i == pkt.size() - 1);
    end
    if (!mark) begin
      for (int i = 0; i < pkt.size() && i < MaxBytes; i++) sent_store[i] = pkt[i];
      sent_len = (pkt.size() < MaxBytes) ? pkt.size() : MaxBytes;
      if (sent_len > written_span) written_span = sent_len;
    end
  endtask

  task automatic fill_random(input int unsigned len);
    pkt.delete();
    repeat (len) pkt.push_back(8'($urandom_range(255)));
  endtask

  // Copies the stored packet; bytes beyond the store depth are random.
  task automatic fill_from_store(input int unsigned len);
    pkt.delete();
    for (int unsigned i = 0; i < len; i++) begin
      pkt.push_back((i < MaxBytes) ? sent_store[i] : 8'($urandom_range(255)));
    end
  endtask

  // Mostly short packets, now and then a long one or one past the store depth.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(6, 1);
    if (r < 95) return $urandom_range(24, 7);
    if (r < 99) return $urandom_range(255, 25);
    return $urandom_range(270, 256);
  endfunction

  // One random packet. Resends exceed what originals wrote only past the store depth.
  task automatic random_packet();
    int unsigned pick;
    int unsigned len;
    int unsigned span;
    int unsigned pos;
    pick = $urandom_range(99);
    if (written_span == 0 || pick < 30) begin
      fill_random(pick_length());
      send_packet(1'b0);
    end else if (pick < 65) begin
      // Faithful resend; a saturated original may be resent with extra bytes.
      len = (sent_len == MaxBytes) ? MaxBytes + $urandom_range(4) : sent_len;
      fill_from_store(len);
      send_packet(1'b1);
    end else if (pick < 82) begin
      fill_from_store(sent_len);
      pos = $urandom_range(sent_len - 1);
      pkt[pos] = pkt[pos] ^ 8'($urandom_range(255, 1));
      send_packet(1'b1);
    end else begin
      span = (written_span == MaxBytes) ? MaxBytes + 8 : written_span;
      fill_from_store($urandom_range(span, 1));
      send_packet(1'b1);
    end
  endtask

  // Short packets of the extreme values, every verdict path and the single-byte case.
  task automatic directed_packets();
    pkt = {8'h00};                      send_packet(1'b0);
    pkt = {8'h00};                      send_packet(1'b1);
    pkt = {8'hFF};                      send_packet(1'b1);
    pkt = {8'h00};                      send_packet(1'b1);
    pkt = {8'hFF, 8'h5A, 8'hA5};        send_packet(1'b0);
    pkt = {8'hFF, 8'h5A, 8'hA5};        send_packet(1'b1);
    pkt = {8'hFF, 8'h5A};               send_packet(1'b1);
    pkt = {8'h00, 8'hFF, 8'h80, 8'h01}; send_packet(1'b0);
    pkt = {8'h00, 8'hFF, 8'h80, 8'h01}; send_packet(1'b1);
    pkt = {8'h00, 8'hFF, 8'h80, 8'h01}; send_packet(1'b1);
  endtask

  // Holds the output off for a long stretch while short packets keep coming,
  // so the queue fills and the input stalls.
  task automatic burst_against_stall();
    hold_request = 60;
    repeat (10) begin
      fill_random(1);
      send_packet(1'b0);
      fill_from_store(1);
      send_packet(1'($urandom_range(1)));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Result side: checks each accepted verdict and drives ready with random stalls.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) tracker.check_verdict(is_duplicate_o);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Ends the run if nothing is accepted on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned sender_idle [4];
    int unsigned receiver_stall [4];
    int unsigned target;
    bit          burst_done;
    sender_idle    = '{0, 82, 0, 30};
    receiver_stall = '{0, 0, 82, 30};
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = sender_idle[ph];
      stall_pct     = receiver_stall[ph];
      if (ph == 0) directed_packets();
      // A packet past the store depth and a resend of it with extra bytes.
      if (ph == 2) begin
        fill_random(260);
        send_packet(1'b0);
        fill_from_store(262);
        send_packet(1'b1);
      end
      target     = bytes_sent + PhaseBytes;
      burst_done = 1'b0;
      while (bytes_sent < target) begin
        random_packet();
        if (!burst_done && bytes_sent + PhaseBytes / 2 >= target) begin
          burst_against_stall();
          burst_done = 1'b1;
        end
      end
      // The sender pauses until every verdict of the phase has come back.
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rdd_pkg.sv
hw/rtl/rdd_front.sv
hw/rtl/rdd_fifo.sv
hw/rtl/rdd_back.sv
hw/rtl/resend_duplicate_detector_unit.sv
tb/resend_duplicate_detector_unit_tb.sv
